[hdl/hmm_two_state_log_forward_top_assert.svh]
// Assertion macros for the two-state log-domain forward block.
// Used by hmm_two_state_log_forward_top; no other dependencies.
`ifndef HMM_TWO_STATE_LOG_FORWARD_TOP_ASSERT_SVH
`define HMM_TWO_STATE_LOG_FORWARD_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HMMFWD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hmmfwd assertion failed (same cycle)");
// next-cycle implication
`define HMMFWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hmmfwd assertion failed (next cycle)");
`else
`define HMMFWD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HMMFWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/hmmfwd_pkg.sv]
// Shared types, constants and elaboration-time tables for the HMM forward block.
// No dependencies.
package hmmfwd_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LOG_INIT0  = 3'd0,
		REG_LOG_INIT1  = 3'd1,
		REG_LOG_TRAN00 = 3'd2,
		REG_LOG_TRAN01 = 3'd3,
		REG_LOG_TRAN10 = 3'd4,
		REG_LOG_TRAN11 = 3'd5,
		REG_EMIT_PROB0 = 3'd6,
		REG_EMIT_PROB1 = 3'd7
	} reg_idx_t;

	localparam int CFG_DATA_W = 56;

	// config write transfer
	typedef struct packed {
		logic                  en;
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// observation codes
	localparam logic [1:0] CODE_ABSENT  = 2'd0;
	localparam logic [1:0] CODE_PRESENT = 2'd1;

	localparam int NUM_CODE_PORTS = 7;
	localparam int QUEUE_DEPTH    = 2;

	// fixed-point constants
	localparam logic [63:0] LN2_Q16      = 64'd45426;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;
	localparam int          CORR_SHIFT   = 12;

	// table widths
	localparam int LN_MAG_W     = 19;  // |ln(x/255)| in Q16 fits here
	localparam int EMAG_W       = 22;  // sum of up to eight magnitudes
	localparam int CORR_W       = 16;
	localparam int CORR_ENTRIES = 256; // entries past this are all zero
	localparam int CORR_IDX_W   = $clog2(CORR_ENTRIES);

	typedef logic [LN_MAG_W-1:0] ln_tab_t [256];
	typedef logic [CORR_W-1:0]   corr_tab_t [CORR_ENTRIES];

	// binary log of a Q16 value in [1, 256), fraction truncated, by repeated squaring
	function automatic logic [63:0] log2_q16(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] e;
		logic [63:0] frac;
		v = v_in;
		e = '0;
		frac = '0;
		for (int i = 0; i < 40; i++) begin
			if (v >= 64'd131072) begin
				v = v >> 1;
				e = e + 64'd1;
			end
		end
		for (int i = 15; i >= 0; i--) begin
			v = (v * v) >> 16;
			if (v >= 64'd131072) begin
				v = v >> 1;
				frac[i] = 1'b1;
			end
		end
		return (e << 16) | frac;
	endfunction

	// magnitude of ln(num/255) in Q16; entry zero is flagged separately as minus infinity
	function automatic ln_tab_t build_ln_tab();
		ln_tab_t     t;
		logic [63:0] top;
		logic [63:0] here;
		logic [63:0] d;
		logic [63:0] m;
		top = log2_q16(64'd255 << 16);
		t[0] = '0;
		for (int n = 1; n < 256; n++) begin
			here = log2_q16(64'(n) << 16);
			d = (top > here) ? top - here : 64'd0;
			m = (d * LN2_Q16 + 64'd32768) >> 16;
			t[n] = m[LN_MAG_W-1:0];
		end
		return t;
	endfunction

	// log-sum-exp correction ln(1 + e^(-i/16)) in Q16
	function automatic corr_tab_t build_corr_tab();
		corr_tab_t   t;
		logic [63:0] y;
		logic [63:0] m;
		logic [63:0] l;
		logic [63:0] c;
		y = 64'd1 << 32;
		for (int i = 0; i < CORR_ENTRIES; i++) begin
			m = 64'd65536 + ((y + 64'd32768) >> 16);
			l = log2_q16(m);
			c = (l * LN2_Q16 + 64'd32768) >> 16;
			t[i] = c[CORR_W-1:0];
			y = (y * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam ln_tab_t   LN_TAB   = build_ln_tab();
	localparam corr_tab_t CORR_TAB = build_corr_tab();

endpackage

[hdl/hmm_two_state_log_forward_top.sv]
// Two-state HMM log-domain forward recursion: one time step per transfer, Q.16 alphas.
// The front end scores each step of observations; a two-entry queue parts it from
// the back end, which runs the alpha recursion through its alpha registers and holds
// the result in an output register; a step passes the stage register, the queue and
// the output register in turn. Sustained rate is one time step per clock while the
// output is not stalled. The rate is set by the alpha update, whose result feeds the
// next step in the next cycle. Configuration writes are taken in any cycle (cfg_ready
// is always high) and must only be issued while no step is in flight. Depends on
// hmmfwd_pkg, hmmfwd_front, hmmfwd_queue, hmmfwd_back and the assertion header.
`include "hmm_two_state_log_forward_top_assert.svh"

module hmm_two_state_log_forward_top import hmmfwd_pkg::*; #(
	parameter int NUM_ITEMS        = 7,
	parameter int LOG_WIDTH        = 32,
	parameter int CORRECTION_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [55:0] cfg_data,
	// observation channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        start_of_sequence,
	input  logic [1:0]  code_item0,
	input  logic [1:0]  code_item1,
	input  logic [1:0]  code_item2,
	input  logic [1:0]  code_item3,
	input  logic [1:0]  code_item4,
	input  logic [1:0]  code_item5,
	input  logic [1:0]  code_item6,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] alpha_state0,
	output logic [31:0] alpha_state1
);

	localparam int QW = 2 * LOG_WIDTH + 1;

	cfg_wr_t                          cfg;
	logic [NUM_CODE_PORTS-1:0][1:0]   codes;
	q_status_t                        q_stat;
	logic                             q_push;
	logic                             q_pop;
	logic [QW-1:0]                    q_wdata;
	logic [QW-1:0]                    q_rdata;

	assign cfg_ready = 1'b1;
	assign cfg.en    = cfg_valid && cfg_ready;
	assign cfg.idx   = reg_idx_t'(cfg_index);
	assign cfg.data  = cfg_data;

	assign codes = {code_item6, code_item5, code_item4, code_item3,
	                code_item2, code_item1, code_item0};

	hmmfwd_front #(
		.NUM_ITEMS (NUM_ITEMS),
		.LOG_WIDTH (LOG_WIDTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.start_of_sequence (start_of_sequence),
		.codes             (codes),
		.q_stat            (q_stat),
		.q_push            (q_push),
		.q_data            (q_wdata)
	);

	hmmfwd_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.stat      (q_stat)
	);

	hmmfwd_back #(
		.LOG_WIDTH        (LOG_WIDTH),
		.CORRECTION_DEPTH (CORRECTION_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_stat       (q_stat),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.alpha_state0 (alpha_state0),
		.alpha_state1 (alpha_state1)
	);

	// a step taken from the queue is on the output next cycle
	`HMMFWD_ASSERT_NEXT(a_pop_loads_out, clk, arst_n, q_pop, out_valid)
	// a drained output with nothing queued goes idle
	`HMMFWD_ASSERT_NEXT(a_out_drains, clk, arst_n, out_valid && !out_stall && q_stat.empty, !out_valid)
	// the front end only stalls on a full queue
	`HMMFWD_ASSERT_IMPL(a_stall_on_full, clk, arst_n, in_stall, q_stat.full && !q_stat.empty)

endmodule

[hdl/hmmfwd_front.sv]
// Front end: accepts observation steps, computes both emission scores, feeds the queue.
// Depends on hmmfwd_pkg (tables, codes, config struct).
module hmmfwd_front import hmmfwd_pkg::*; #(
	parameter int NUM_ITEMS = 7,
	parameter int LOG_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfg_wr_t                             cfg,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                start_of_sequence,
	input  logic [NUM_CODE_PORTS-1:0][1:0]      codes,
	input  q_status_t                           q_stat,
	output logic                                q_push,
	output logic [2*LOG_WIDTH:0]                q_data
);

	localparam int CW = ((LOG_WIDTH > EMAG_W) ? LOG_WIDTH : EMAG_W) + 1;
	localparam logic signed [LOG_WIDTH-1:0] NEG_INF = {1'b1, {(LOG_WIDTH-1){1'b0}}};
	localparam logic [CW-1:0] SUM_LIMIT = CW'(1) << (LOG_WIDTH-1);

	logic [CFG_DATA_W-1:0] prob0_q;
	logic [CFG_DATA_W-1:0] prob1_q;

	logic [LN_MAG_W-1:0] mag0 [NUM_ITEMS];
	logic [LN_MAG_W-1:0] mag1 [NUM_ITEMS];
	logic                inf0 [NUM_ITEMS];
	logic                inf1 [NUM_ITEMS];

	logic [EMAG_W-1:0]          sum0;
	logic [EMAG_W-1:0]          sum1;
	logic                       any_inf0;
	logic                       any_inf1;
	logic signed [LOG_WIDTH-1:0] emis0;
	logic signed [LOG_WIDTH-1:0] emis1;

	logic                        vld_s1;
	logic                        start_s1;
	logic signed [LOG_WIDTH-1:0] e0_s1;
	logic signed [LOG_WIDTH-1:0] e1_s1;

	// saturate the negated magnitude sum; a zero probability wins outright
	function automatic logic signed [LOG_WIDTH-1:0] to_emis(input logic any_inf,
		input logic [EMAG_W-1:0] sum);
		logic [CW-1:0] sx;
		sx = CW'(sum);
		if (any_inf || sx >= SUM_LIMIT) return NEG_INF;
		return LOG_WIDTH'(CW'(0) - sx);
	endfunction

	// per-item table lookups
	for (genvar k = 0; k < NUM_ITEMS; k++) begin : g_item
		if (k < NUM_CODE_PORTS) begin : g_port
			logic [1:0] code;
			logic [7:0] b0;
			logic [7:0] b1;
			logic [7:0] num0;
			logic [7:0] num1;
			logic       used;
			assign code = codes[k];
			assign b0   = prob0_q[8*k +: 8];
			assign b1   = prob1_q[8*k +: 8];
			assign num0 = (code == CODE_ABSENT) ? b0 : ~b0;
			assign num1 = (code == CODE_ABSENT) ? b1 : ~b1;
			assign used = (code == CODE_ABSENT) || (code == CODE_PRESENT);
			assign mag0[k] = used ? LN_TAB[num0] : '0;
			assign mag1[k] = used ? LN_TAB[num1] : '0;
			assign inf0[k] = used && (num0 == 8'd0);
			assign inf1[k] = used && (num1 == 8'd0);
		end else begin : g_none
			// no port behind this item: treated as missing
			assign mag0[k] = '0;
			assign mag1[k] = '0;
			assign inf0[k] = 1'b0;
			assign inf1[k] = 1'b0;
		end
	end

	// emission sums
	always_comb begin
		sum0 = '0;
		sum1 = '0;
		any_inf0 = 1'b0;
		any_inf1 = 1'b0;
		for (int i = 0; i < NUM_ITEMS; i++) begin
			sum0 = sum0 + EMAG_W'(mag0[i]);
			sum1 = sum1 + EMAG_W'(mag1[i]);
			any_inf0 = any_inf0 | inf0[i];
			any_inf1 = any_inf1 | inf1[i];
		end
		emis0 = to_emis(any_inf0, sum0);
		emis1 = to_emis(any_inf1, sum1);
	end

	// handshake: hold the stage while the queue is full
	assign in_stall = vld_s1 && q_stat.full;
	assign q_push   = vld_s1 && !q_stat.full;
	assign q_data   = {start_s1, e0_s1, e1_s1};

	// emission probability registers and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob0_q <= '0;
			prob1_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg.en && cfg.idx == REG_EMIT_PROB0) begin
				prob0_q <= cfg.data;
			end
			if (cfg.en && cfg.idx == REG_EMIT_PROB1) begin
				prob1_q <= cfg.data;
			end
			if (!in_stall) begin
				vld_s1 <= in_valid;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			start_s1 <= start_of_sequence;
			e0_s1    <= emis0;
			e1_s1    <= emis1;
		end
	end

endmodule

[hdl/hmmfwd_queue.sv]
// Short FIFO between front and back ends.
// Depends on hmmfwd_pkg (status struct).
module hmmfwd_queue import hmmfwd_pkg::*; #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output q_status_t        stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign stat.full  = (count_q == NW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hdl/hmmfwd_back.sv]
// Back end: log-domain forward recursion, alpha state and output register.
// Depends on hmmfwd_pkg (correction table, register indexes, config struct).
module hmmfwd_back import hmmfwd_pkg::*; #(
	parameter int LOG_WIDTH        = 32,
	parameter int CORRECTION_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_wr_t              cfg,
	input  q_status_t            q_stat,
	input  logic [2*LOG_WIDTH:0] q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          alpha_state0,
	output logic [31:0]          alpha_state1
);

	localparam int W  = LOG_WIDTH;
	localparam int DW = ((W > CORR_W) ? W : CORR_W) + 2;
	localparam int XW = (W > 32) ? W : 32;
	localparam int LIM = (CORRECTION_DEPTH < CORR_ENTRIES) ? CORRECTION_DEPTH : CORR_ENTRIES;

	localparam logic signed [W-1:0]  NEG_INF = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0]  POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [DW-1:0] NI_D    = DW'(NEG_INF);
	localparam logic signed [DW-1:0] MAX_D   = DW'(POS_MAX);
	localparam logic signed [XW-1:0] NI_X    = XW'(NEG_INF);
	localparam logic signed [XW-1:0] MAX_X   = XW'(POS_MAX);
	localparam logic signed [XW-1:0] OUT_MIN = XW'(-64'sd2147483648);
	localparam logic signed [XW-1:0] OUT_MAX = XW'(64'sd2147483647);
	localparam logic [DW-1:0]        CORR_LIMIT = DW'(LIM);

	logic signed [W-1:0] init0_q, init1_q;
	logic signed [W-1:0] tran00_q, tran01_q, tran10_q, tran11_q;
	logic signed [W-1:0] prev0_q, prev1_q;
	logic                out_vld_q;
	logic [31:0]         alpha0_q, alpha1_q;

	logic                start;
	logic signed [W-1:0] e0, e1;
	logic signed [W-1:0] a0, a1;
	logic signed [W-1:0] reg_val;

	function automatic logic signed [W-1:0] sat(input logic signed [DW-1:0] v);
		if (v < NI_D) return NEG_INF;
		if (v > MAX_D) return POS_MAX;
		return v[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] add_inf(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [DW-1:0] s;
		s = DW'(a) + DW'(b);
		if (a == NEG_INF || b == NEG_INF) return NEG_INF;
		return sat(s);
	endfunction

	// max plus table correction on the scaled difference
	function automatic logic signed [W-1:0] lse(input logic signed [W-1:0] a,
		input logic signed [W-1:0] b);
		logic signed [W-1:0]  hi;
		logic signed [W-1:0]  lo;
		logic [DW-1:0]        dif;
		logic [DW-1:0]        idx;
		logic signed [DW-1:0] s;
		if (a > b) begin
			hi = a;
			lo = b;
		end else begin
			hi = b;
			lo = a;
		end
		dif = DW'(hi) - DW'(lo);
		idx = dif >> CORR_SHIFT;
		s = DW'(hi) + $signed(DW'(CORR_TAB[idx[CORR_IDX_W-1:0]]));
		if (lo == NEG_INF) return hi;
		if (idx >= CORR_LIMIT) return hi;
		return sat(s);
	endfunction

	// clamp to the 32-bit result field, minus infinity as the most negative code
	function automatic logic [31:0] to_out(input logic signed [W-1:0] v);
		logic signed [XW-1:0] vx;
		vx = XW'(v);
		if (v == NEG_INF || vx < OUT_MIN) return 32'h8000_0000;
		if (vx > OUT_MAX) return 32'h7fff_ffff;
		return vx[31:0];
	endfunction

	// 32-bit register code to internal format; the most negative code is minus infinity
	function automatic logic signed [W-1:0] from_reg(input logic [31:0] u);
		logic signed [XW-1:0] sx;
		sx = XW'($signed(u));
		if (u == 32'h8000_0000) return NEG_INF;
		if (sx < NI_X) return NEG_INF;
		if (sx > MAX_X) return POS_MAX;
		return sx[W-1:0];
	endfunction

	assign start = q_data[2*W];
	assign e0    = $signed(q_data[2*W-1:W]);
	assign e1    = $signed(q_data[W-1:0]);

	// take the next step once the output register is free or being drained
	assign q_pop = !q_stat.empty && (!out_vld_q || !out_stall);

	assign reg_val = from_reg(cfg.data[31:0]);

	// forward recursion
	always_comb begin
		if (start) begin
			a0 = add_inf(init0_q, e0);
			a1 = add_inf(init1_q, e1);
		end else begin
			a0 = lse(add_inf(add_inf(prev0_q, tran00_q), e0),
			         add_inf(add_inf(prev1_q, tran10_q), e0));
			a1 = lse(add_inf(add_inf(prev0_q, tran01_q), e1),
			         add_inf(add_inf(prev1_q, tran11_q), e1));
		end
	end

	// config registers, alpha state, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init0_q   <= '0;
			init1_q   <= '0;
			tran00_q  <= '0;
			tran01_q  <= '0;
			tran10_q  <= '0;
			tran11_q  <= '0;
			prev0_q   <= '0;
			prev1_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.en) begin
				unique case (cfg.idx)
					REG_LOG_INIT0:  init0_q  <= reg_val;
					REG_LOG_INIT1:  init1_q  <= reg_val;
					REG_LOG_TRAN00: tran00_q <= reg_val;
					REG_LOG_TRAN01: tran01_q <= reg_val;
					REG_LOG_TRAN10: tran10_q <= reg_val;
					REG_LOG_TRAN11: tran11_q <= reg_val;
					REG_EMIT_PROB0, REG_EMIT_PROB1: ; // held in the front end
				endcase
			end
			if (q_pop) begin
				prev0_q   <= a0;
				prev1_q   <= a1;
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			alpha0_q <= to_out(a0);
			alpha1_q <= to_out(a1);
		end
	end

	assign out_valid    = out_vld_q;
	assign alpha_state0 = alpha0_q;
	assign alpha_state1 = alpha1_q;

endmodule

[dv/hmm_two_state_log_forward_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for hmm_two_state_log_forward_top: directed and random observation
// steps under several register settings, checked against an in-bench log-domain predictor.
// Depends on hmmfwd_pkg (register indexes, observation codes) and the forward block RTL.
module hmm_two_state_log_forward_top_tb;
	import hmmfwd_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 64;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_STEPS   = 110;
	localparam int CORR_DEPTH    = 256;
	localparam int CORR_STEP_SHIFT = 12;

	localparam longint          NEG_INF_Q16   = -64'sd2147483648;
	localparam longint          POS_MAX_Q16   = 64'sd2147483647;
	localparam longint unsigned LN2_FIX       = 64'd45426;
	localparam longint unsigned EXP_DECAY_Q32 = 64'd4034748382;

	localparam logic [31:0] LOG_MINUS_INF = 32'h8000_0000;
	localparam logic [31:0] LOG_FLOOR_FIN = 32'h8000_0001;

	localparam logic [1:0] CODE_MISSING     = 2'd2;
	localparam logic [1:0] CODE_MISSING_ALT = 2'd3;

	localparam logic [13:0] ALL_ABSENT      = {7{CODE_ABSENT}};
	localparam logic [13:0] ALL_PRESENT     = {7{CODE_PRESENT}};
	localparam logic [13:0] ALL_MISSING     = {7{CODE_MISSING}};
	localparam logic [13:0] ALL_MISSING_ALT = {7{CODE_MISSING_ALT}};
	localparam logic [13:0] MIXED_CODES     = {CODE_MISSING, CODE_ABSENT, CODE_PRESENT,
		CODE_MISSING_ALT, CODE_MISSING, CODE_PRESENT, CODE_ABSENT};

	typedef struct packed {
		logic            start;
		logic [6:0][1:0] codes;
	} obs_t;

	typedef struct packed {
		logic [31:0] alpha0;
		logic [31:0] alpha1;
	} alpha_pair_t;

	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        cfg_valid         = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index         = '0;
	logic [55:0] cfg_data          = '0;
	logic        in_valid          = 1'b0;
	logic        in_stall;
	logic        start_of_sequence = 1'b0;
	logic [1:0]  code_item0        = '0;
	logic [1:0]  code_item1        = '0;
	logic [1:0]  code_item2        = '0;
	logic [1:0]  code_item3        = '0;
	logic [1:0]  code_item4        = '0;
	logic [1:0]  code_item5        = '0;
	logic [1:0]  code_item6        = '0;
	logic        out_valid;
	logic        out_stall         = 1'b0;
	logic [31:0] alpha_state0;
	logic [31:0] alpha_state1;

	// predictor copy of registers and recursion state
	longint          init_lp    [2];
	longint          tran_lp    [2][2];   // [from][to]
	logic [55:0]     emit_p     [2];
	longint          alpha_prev [2];
	longint          corr_q16   [CORR_DEPTH];
	longint unsigned log2_255;

	obs_t        obs_pending[$];
	alpha_pair_t alpha_expected[$];
	obs_t        obs_on_port;
	alpha_pair_t got_pair;
	alpha_pair_t want_pair;

	logic send_burst = 1'b0;
	logic recv_burst = 1'b0;
	int   gap_left   = 0;
	int   stall_left = 0;
	int   next_long_hold = 150;
	int   long_holds     = 0;
	int   steps_accepted = 0;
	int   results_checked = 0;
	int   seq_starts     = 0;
	int   reg_writes     = 0;
	int   mismatches     = 0;
	int   cycle_count    = 0;

	hmm_two_state_log_forward_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.start_of_sequence (start_of_sequence),
		.code_item0        (code_item0),
		.code_item1        (code_item1),
		.code_item2        (code_item2),
		.code_item3        (code_item3),
		.code_item4        (code_item4),
		.code_item5        (code_item5),
		.code_item6        (code_item6),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.alpha_state0      (alpha_state0),
		.alpha_state1      (alpha_state1)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// binary log of a Q16 value in [1, 256), 16 fraction bits, truncated
	function automatic longint unsigned bin_log_q16(input longint unsigned x);
		longint unsigned ipart;
		longint unsigned frac;
		ipart = 0;
		frac = 0;
		while (x >= 64'd131072 && ipart < 40) begin
			x = x >> 1;
			ipart++;
		end
		for (int i = 15; i >= 0; i--) begin
			x = (x * x) >> 16;
			if (x >= 64'd131072) begin
				x = x >> 1;
				frac = frac | (64'd1 << i);
			end
		end
		return (ipart << 16) | frac;
	endfunction

	// ln(num/255) in Q16, zero probability is minus infinity
	function automatic longint ln_of_prob(input logic [7:0] num);
		longint unsigned here;
		longint unsigned d;
		if (num == 8'd0) return NEG_INF_Q16;
		here = bin_log_q16(64'(num) << 16);
		d = (log2_255 > here) ? log2_255 - here : 64'd0;
		return -longint'((d * LN2_FIX + 64'd32768) >> 16);
	endfunction

	function automatic longint sat_q16(input longint v);
		if (v < NEG_INF_Q16) return NEG_INF_Q16;
		if (v > POS_MAX_Q16) return POS_MAX_Q16;
		return v;
	endfunction

	// minus infinity absorbs any sum
	function automatic longint add_q16(input longint a, input longint b);
		if (a == NEG_INF_Q16 || b == NEG_INF_Q16) return NEG_INF_Q16;
		return sat_q16(a + b);
	endfunction

	// max plus table correction, step 1/16
	function automatic longint lse_q16(input longint a, input longint b);
		longint hi;
		longint lo;
		longint idx;
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		if (lo == NEG_INF_Q16) return hi;
		idx = (hi - lo) >>> CORR_STEP_SHIFT;
		if (idx >= CORR_DEPTH) return hi;
		return sat_q16(hi + corr_q16[idx]);
	endfunction

	function automatic longint emission_q16(input logic [6:0][1:0] codes,
		input logic [55:0] probs);
		longint acc;
		acc = 0;
		for (int k = 0; k < 7; k++) begin
			if (codes[k] == CODE_ABSENT)
				acc = add_q16(acc, ln_of_prob(probs[8*k +: 8]));
			else if (codes[k] == CODE_PRESENT)
				acc = add_q16(acc, ln_of_prob(8'd255 - probs[8*k +: 8]));
		end
		return acc;
	endfunction

	// one time step of the recursion; queues the alphas it produces
	function automatic void forward_step(input obs_t o);
		longint emit [2];
		longint nxt  [2];
		for (int s = 0; s < 2; s++) begin
			emit[s] = emission_q16(o.codes, emit_p[s]);
			if (o.start)
				nxt[s] = add_q16(init_lp[s], emit[s]);
			else
				nxt[s] = lse_q16(add_q16(add_q16(alpha_prev[0], tran_lp[0][s]), emit[s]),
					add_q16(add_q16(alpha_prev[1], tran_lp[1][s]), emit[s]));
		end
		alpha_prev = nxt;
		alpha_expected.push_back(alpha_pair_t'{nxt[0][31:0], nxt[1][31:0]});
	endfunction

	function automatic void queue_obs(input logic start, input logic [13:0] codes);
		obs_pending.push_back(obs_t'({start, codes}));
		if (start) seq_starts++;
	endfunction

	// log register draw: minus infinity, zero, floor, wide and narrow negatives
	function automatic logic [31:0] draw_log();
		case ($urandom_range(0, 9))
			0: return LOG_MINUS_INF;
			1: return 32'd0;
			2: return LOG_FLOOR_FIN;
			3, 4: return 32'd0 - $urandom_range(0, 32'h7FFF_FFFF);
			default: return 32'd0 - $urandom_range(0, 6 * 65536);
		endcase
	endfunction

	function automatic logic [55:0] draw_probs();
		logic [55:0] p;
		for (int k = 0; k < 7; k++) begin
			case ($urandom_range(0, 7))
				0: p[8*k +: 8] = 8'd0;
				1: p[8*k +: 8] = 8'd255;
				default: p[8*k +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return p;
	endfunction

	// one register write transfer, mirrored into the predictor
	task automatic write_reg(input reg_idx_t idx, input logic [55:0] value);
		longint lv;
		lv = longint'($signed(value[31:0]));
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LOG_INIT0:  init_lp[0] = lv;
			REG_LOG_INIT1:  init_lp[1] = lv;
			REG_LOG_TRAN00: tran_lp[0][0] = lv;
			REG_LOG_TRAN01: tran_lp[0][1] = lv;
			REG_LOG_TRAN10: tran_lp[1][0] = lv;
			REG_LOG_TRAN11: tran_lp[1][1] = lv;
			REG_EMIT_PROB0: emit_p[0] = value;
			REG_EMIT_PROB1: emit_p[1] = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic program_regs(input logic [31:0] i0, i1, t00, t01, t10, t11,
		input logic [55:0] p0, p1);
		write_reg(REG_LOG_INIT0,  56'($signed(i0)));
		write_reg(REG_LOG_INIT1,  56'($signed(i1)));
		write_reg(REG_LOG_TRAN00, 56'($signed(t00)));
		write_reg(REG_LOG_TRAN01, 56'($signed(t01)));
		write_reg(REG_LOG_TRAN10, 56'($signed(t10)));
		write_reg(REG_LOG_TRAN11, 56'($signed(t11)));
		write_reg(REG_EMIT_PROB0, p0);
		write_reg(REG_EMIT_PROB1, p1);
		@(negedge clk);
	endtask

	// hold the sender until every step is out, then let the pipe settle
	task automatic drain();
		do @(negedge clk);
		while (obs_pending.size() != 0 || in_valid || alpha_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// observation driver: one step per transfer, random gap after each outside send bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				forward_step(obs_on_port);
				steps_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || obs_pending.size() == 0) begin
					if (gap_left > 0) gap_left--;
					in_valid <= 1'b0;
				end else begin
					obs_on_port = obs_pending.pop_front();
					in_valid          <= 1'b1;
					start_of_sequence <= obs_on_port.start;
					code_item0        <= obs_on_port.codes[0];
					code_item1        <= obs_on_port.codes[1];
					code_item2        <= obs_on_port.codes[2];
					code_item3        <= obs_on_port.codes[3];
					code_item4        <= obs_on_port.codes[4];
					code_item5        <= obs_on_port.codes[5];
					code_item6        <= obs_on_port.codes[6];
					gap_left = send_burst ? 0 : $urandom_range(0, 8);
				end
			end
		end
	end

	// result monitor: compare each transfer with the oldest expected pair
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got_pair = alpha_pair_t'{alpha_state0, alpha_state1};
				if (alpha_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %0d / %0d", $time,
						$signed(got_pair.alpha0), $signed(got_pair.alpha1));
					mismatches++;
				end else begin
					want_pair = alpha_expected.pop_front();
					if (got_pair.alpha0 !== want_pair.alpha0) begin
						$display("%0t: alpha_state0 expected %0d got %0d", $time,
							$signed(want_pair.alpha0), $signed(got_pair.alpha0));
						mismatches++;
					end
					if (got_pair.alpha1 !== want_pair.alpha1) begin
						$display("%0t: alpha_state1 expected %0d got %0d", $time,
							$signed(want_pair.alpha1), $signed(got_pair.alpha1));
						mismatches++;
					end
				end
				results_checked++;
				// now and then a long hold-off so the input side backs up
				if (results_checked >= next_long_hold && obs_pending.size() >= 20) begin
					stall_left = LONG_HOLD;
					next_long_hold += 300;
					long_holds++;
				end else begin
					stall_left = recv_burst ? 0 : $urandom_range(0, 8);
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, alpha_expected.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		longint unsigned decay;
		int              queued;
		int              seq_len;
		logic            noisy;

		// correction table ln(1 + e^(-i/16)) and reset state of the predictor
		log2_255 = bin_log_q16(64'd255 << 16);
		decay = 64'd1 << 32;
		for (int i = 0; i < CORR_DEPTH; i++) begin
			corr_q16[i] = longint'((bin_log_q16(64'd65536 + ((decay + 64'd32768) >> 16))
				* LN2_FIX + 64'd32768) >> 16);
			decay = (decay * EXP_DECAY_Q32 + (64'd1 << 31)) >> 32;
		end
		init_lp    = '{0, 0};
		tran_lp    = '{'{0, 0}, '{0, 0}};
		emit_p     = '{56'd0, 56'd0};
		alpha_prev = '{0, 0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: steps without start use the reset alphas
		queue_obs(1'b0, ALL_MISSING);
		queue_obs(1'b0, ALL_PRESENT);
		queue_obs(1'b0, ALL_ABSENT);
		queue_obs(1'b0, ALL_MISSING);
		queue_obs(1'b1, ALL_MISSING_ALT);
		drain();

		// ordinary chain, one transition at minus infinity
		program_regs(-32'sd45426, -32'sd45426, -32'sd7000, -32'sd60000, LOG_MINUS_INF,
			-32'sd3000, 56'hFF00F01080FE01, 56'h7F4020C0E00A33);
		queue_obs(1'b1, ALL_ABSENT);
		queue_obs(1'b0, ALL_PRESENT);
		queue_obs(1'b0, MIXED_CODES);
		queue_obs(1'b0, ALL_MISSING);
		queue_obs(1'b0, ALL_MISSING_ALT);
		queue_obs(1'b1, ALL_PRESENT);
		queue_obs(1'b0, ALL_ABSENT);
		drain();

		// every log at minus infinity
		program_regs(LOG_MINUS_INF, LOG_MINUS_INF, LOG_MINUS_INF, LOG_MINUS_INF,
			LOG_MINUS_INF, LOG_MINUS_INF, {7{8'hFF}}, {7{8'hFF}});
		queue_obs(1'b1, ALL_ABSENT);
		queue_obs(1'b0, ALL_MISSING);
		drain();

		// most negative finite start saturates into minus infinity
		program_regs(LOG_FLOOR_FIN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
			{7{8'h40}}, {7{8'hC0}});
		queue_obs(1'b1, ALL_ABSENT);
		queue_obs(1'b0, ALL_PRESENT);
		queue_obs(1'b0, ALL_PRESENT);
		drain();

		// random settings, mostly well-formed sequences
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			program_regs(draw_log(), draw_log(), draw_log(), draw_log(), draw_log(),
				draw_log(), draw_probs(), draw_probs());
			send_burst = (ph % 3 == 1);
			recv_burst = (ph % 4 == 2);
			queued = 0;
			while (queued < PHASE_STEPS) begin
				seq_len = $urandom_range(1, 24);
				noisy = ($urandom_range(0, 7) == 0);
				for (int n = 0; n < seq_len; n++) begin
					queue_obs(noisy ? 1'($urandom) : (n == 0), 14'($urandom));
					queued++;
				end
			end
			drain();
		end

		$display("Ran %0d time steps in %0d sequences across %0d register writes,",
			steps_accepted, seq_starts, reg_writes);
		$display("%0d results compared, %0d long output hold-offs, %0d mismatches.",
			results_checked, long_holds, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/hmmfwd_pkg.sv
hdl/hmmfwd_front.sv
hdl/hmmfwd_queue.sv
hdl/hmmfwd_back.sv
hdl/hmm_two_state_log_forward_top.sv
dv/hmm_two_state_log_forward_top_tb.sv
